// ----- hw/rtl/two_float_level_indicator_assert.svh -----
// Assertion macros for the two-float level indicator.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef TWO_FLOAT_LEVEL_INDICATOR_ASSERT_SVH
`define TWO_FLOAT_LEVEL_INDICATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tfli_pkg.sv -----
// Shared types and constants for the two-float level indicator.
// Depends on nothing; used by all modules.
`default_nettype none

package tfli_pkg;

  // Width of the configuration registers and of the write data.
  localparam int CfgWidth = 16;
  // Width of the configuration register index.
  localparam int CfgIdxWidth = 1;

  // Reset values of the configuration registers.
  localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
  localparam logic [CfgWidth-1:0] BlinkReset = 16'd500;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_BLINK    = 1'b1
  } cfg_reg_e;

  // Reported tank level.
  typedef enum logic [1:0] {
    LVL_LOW   = 2'd0,
    LVL_MID   = 2'd1,
    LVL_HIGH  = 2'd2,
    LVL_FAULT = 2'd3
  } level_e;

  // Per-tick control shared by the state-holding units.
  typedef struct packed {
    logic step;  // a regular tick is processed this cycle
    logic seed;  // the tick is the first one after reset
  } tick_ctl_t;

  // One result item.
  typedef struct packed {
    level_e level;
    logic   led_green;
    logic   led_yellow;
    logic   led_red;
    logic   mirror_mid;
    logic   mirror_top;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tfli_if.sv -----
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on nothing beyond the language; used by the top level.
`default_nettype none

// Tick channel: one item carries both float pin levels.
interface tfli_in_if;
  logic valid;
  logic ready;
  logic mid_pin_level;
  logic top_pin_level;

  modport source (output valid, output mid_pin_level, output top_pin_level, input ready);
  modport sink (input valid, input mid_pin_level, input top_pin_level, output ready);
endinterface

// Result channel: one item carries the level, lamps and mirror pins.
interface tfli_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] level;
  logic       led_green;
  logic       led_yellow;
  logic       led_red;
  logic       mirror_mid;
  logic       mirror_top;

  modport source (
    output valid, output level, output led_green, output led_yellow,
    output led_red, output mirror_mid, output mirror_top, input ready
  );
  modport sink (
    input valid, input level, input led_green, input led_yellow,
    input led_red, input mirror_mid, input mirror_top, output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/two_float_level_indicator.sv -----
// Top level of the two-float level indicator: channels, config, result register.
// Depends on tfli_pkg, tfli_if, tfli_debounce, tfli_blink and the assert header.
`default_nettype none
`include "two_float_level_indicator_assert.svh"

// Each millisecond tick item carries the middle and top float pin levels (low
// means the switch is on) and yields exactly one result item with the level,
// the three lamp drives and the two mirror pins. The block takes one item per
// clock cycle with no gap while the result channel is not stalled. An accepted
// item waits in the input register, and its result is loaded into the result
// register once that register is empty or its item is taken; the result is
// offered from the result register. Under back-pressure both registers hold
// their items, so the input stalls once two items are waiting. The first tick
// after reset seeds the debounced state of both switches. Configuration writes
// (debounce_ticks at index 0, blink_ticks at index 1) take effect on the next
// tick processed.
module two_float_level_indicator #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tfli_in_if.sink                               in_i,
  tfli_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tfli_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [tfli_pkg::CfgWidth-1:0]    cfg_data_i
);

  logic [tfli_pkg::CfgWidth-1:0] debounce_ticks_q;
  logic [tfli_pkg::CfgWidth-1:0] blink_ticks_q;

  logic                s1_valid_q, s1_valid_d;
  logic                s1_mid_on_q;
  logic                s1_top_on_q;
  logic                seeded_q, seeded_d;
  logic                out_valid_q, out_valid_d;
  tfli_pkg::result_t   result_q, result_d;
  tfli_pkg::tick_ctl_t ctl;

  logic in_accept;
  logic out_adv;
  logic mid_stable_on;
  logic top_stable_on;
  logic blink_on;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= tfli_pkg::DebounceReset;
      blink_ticks_q    <= tfli_pkg::BlinkReset;
    end else if (cfg_we_i) begin
      unique case (tfli_pkg::cfg_reg_e'(cfg_idx_i))
        tfli_pkg::REG_DEBOUNCE: debounce_ticks_q <= cfg_data_i;
        tfli_pkg::REG_BLINK:    blink_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the result register frees up when it is empty or taken.
  assign out_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || out_adv;
  assign in_accept   = in_i.valid && in_i.ready;
  assign ctl.step    = s1_valid_q && out_adv && seeded_q;
  assign ctl.seed    = s1_valid_q && out_adv && !seeded_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    seeded_d    = seeded_q || ctl.seed;
    out_valid_d = out_valid_q;
    if (ctl.step || ctl.seed) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: switch-on flags of the accepted tick.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mid_on_q <= !in_i.mid_pin_level;
      s1_top_on_q <= !in_i.top_pin_level;
    end
  end

  tfli_debounce #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_mid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sample_on_i     (s1_mid_on_q),
    .debounce_ticks_i(debounce_ticks_q),
    .stable_on_o     (mid_stable_on)
  );

  tfli_debounce #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sample_on_i     (s1_top_on_q),
    .debounce_ticks_i(debounce_ticks_q),
    .stable_on_o     (top_stable_on)
  );

  tfli_blink #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_blink (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .blink_ticks_i(blink_ticks_q),
    .blink_on_o   (blink_on)
  );

  // Level decode and lamp drives from the committed switch states.
  always_comb begin
    if (top_stable_on) begin
      result_d.level = mid_stable_on ? tfli_pkg::LVL_LOW : tfli_pkg::LVL_MID;
    end else begin
      result_d.level = mid_stable_on ? tfli_pkg::LVL_FAULT : tfli_pkg::LVL_HIGH;
    end
    result_d.led_green  = (result_d.level == tfli_pkg::LVL_LOW);
    result_d.led_yellow = (result_d.level == tfli_pkg::LVL_MID);
    result_d.led_red    = (result_d.level == tfli_pkg::LVL_HIGH) ||
                          ((result_d.level == tfli_pkg::LVL_FAULT) && blink_on);
    result_d.mirror_mid = !mid_stable_on;
    result_d.mirror_top = !top_stable_on;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctl.step || ctl.seed) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.level      = result_q.level;
  assign out_o.led_green  = result_q.led_green;
  assign out_o.led_yellow = result_q.led_yellow;
  assign out_o.led_red    = result_q.led_red;
  assign out_o.mirror_mid = result_q.mirror_mid;
  assign out_o.mirror_top = result_q.mirror_top;

  // Only the first processed tick may seed the channels.
  `TFLI_ASSERT_NOW(a_seed_once, clk_i, rst_ni, seeded_q, !ctl.seed,
    "seed requested after the channels were already seeded")

  // A processed tick always leaves a result waiting.
  `TFLI_ASSERT_NEXT(a_tick_gives_result, clk_i, rst_ni, ctl.step || ctl.seed,
    out_valid_q && seeded_q, "processed tick did not produce a result")

  // A stalled input register keeps its item.
  `TFLI_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !out_adv,
    s1_valid_q && $stable(s1_mid_on_q) && $stable(s1_top_on_q),
    "input register lost its item while stalled")

  // Green and yellow lamps agree with the decoded level.
  `TFLI_ASSERT_NOW(a_lamps_match, clk_i, rst_ni, out_valid_q,
    (result_q.led_green == (result_q.level == tfli_pkg::LVL_LOW)) &&
    (result_q.led_yellow == (result_q.level == tfli_pkg::LVL_MID)),
    "lamp drives disagree with the level")

endmodule

`default_nettype wire

// ----- hw/rtl/tfli_debounce.sv -----
// One debounced float-switch channel: raw reading, committed reading, age.
// Depends on tfli_pkg for the tick control struct and register width.
`default_nettype none

module tfli_debounce #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tfli_pkg::tick_ctl_t           ctl_i,
  input  wire logic                          sample_on_i,
  input  wire logic [tfli_pkg::CfgWidth-1:0] debounce_ticks_i,
  output logic                               stable_on_o
);

  localparam int CmpWidth = (COUNT_WIDTH > tfli_pkg::CfgWidth) ? COUNT_WIDTH
                                                                : tfli_pkg::CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] AgeMax = {COUNT_WIDTH{1'b1}};

  logic                   raw_q, raw_d;
  logic                   stable_q, stable_d;
  logic [COUNT_WIDTH-1:0] age_q, age_d;

  // Next state: seed on the first tick, otherwise age the reading and commit.
  always_comb begin
    raw_d    = raw_q;
    stable_d = stable_q;
    age_d    = age_q;
    if (ctl_i.seed) begin
      raw_d    = sample_on_i;
      stable_d = sample_on_i;
      age_d    = '0;
    end else if (ctl_i.step) begin
      if (sample_on_i != raw_q) begin
        raw_d = sample_on_i;
        age_d = '0;
      end else if (age_q != AgeMax) begin
        age_d = age_q + 1'b1;
      end
      if ((raw_d != stable_q) &&
          (CmpWidth'(age_d) >= CmpWidth'(debounce_ticks_i))) begin
        stable_d = raw_d;
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      age_q    <= '0;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      age_q    <= age_d;
    end
  end

  // The result of a tick uses the committed reading after that tick.
  assign stable_on_o = stable_d;

endmodule

`default_nettype wire

// ----- hw/rtl/tfli_blink.sv -----
// Free-running fault blink phase, toggled every blink setting ticks.
// Depends on tfli_pkg for the tick control struct and register width.
`default_nettype none

module tfli_blink #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tfli_pkg::tick_ctl_t           ctl_i,
  input  wire logic [tfli_pkg::CfgWidth-1:0] blink_ticks_i,
  output logic                               blink_on_o
);

  localparam int CmpWidth = (COUNT_WIDTH > tfli_pkg::CfgWidth) ? COUNT_WIDTH
                                                                : tfli_pkg::CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                   on_q, on_d;

  // Saturating tick count; wraps to zero and toggles once it meets the setting.
  always_comb begin
    elapsed_d   = elapsed_q;
    on_d        = on_q;
    elapsed_inc = (elapsed_q == CountMax) ? CountMax : elapsed_q + 1'b1;
    if (ctl_i.seed) begin
      elapsed_d = '0;
      on_d      = 1'b1;
    end else if (ctl_i.step) begin
      if (CmpWidth'(elapsed_inc) >= CmpWidth'(blink_ticks_i)) begin
        elapsed_d = '0;
        on_d      = !on_q;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  // Blink state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      on_q      <= 1'b1;
    end else begin
      elapsed_q <= elapsed_d;
      on_q      <= on_d;
    end
  end

  assign blink_on_o = on_d;

endmodule

`default_nettype wire
